FILE: sv/svf_pkg.sv
// shared types and constants for the clipped state variable filter
`default_nettype none
package svf_pkg;

  // default number of fractional bits of the band and low state
  localparam int FRAC_BITS_DEF = 8;
  // integer bits of a sample and of each state value
  localparam int SAMPLE_W      = 8;
  // coefficient format, unsigned Q1.14
  localparam int COEF_W        = 15;
  localparam int COEF_FRAC     = 14;
  localparam logic [COEF_W-1:0] COEF_RESET = 15'd1638;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIGH,
    ST_MUL_HIGH,
    ST_BAND,
    ST_MUL_BAND,
    ST_LOW,
    ST_OUT
  } svf_state_t;

  // datapath controls driven by the sequencer
  typedef struct packed {
    logic load_in;
    logic do_high;
    logic mul_en;
    logic mul_sel_band;
    logic do_band;
    logic do_low;
    logic load_out;
  } svf_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/svf_if.sv
// valid/ready channel interfaces for samples, results and coefficient writes
`default_nettype none
interface svf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [svf_pkg::SAMPLE_W-1:0] sample;
  logic                                restart;
  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface svf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [svf_pkg::SAMPLE_W-1:0] low_out;
  logic signed [svf_pkg::SAMPLE_W-1:0] high_out;
  modport source (output valid, output low_out, output high_out, input ready);
  modport sink   (input valid, input low_out, input high_out, output ready);
endinterface

interface svf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [svf_pkg::COEF_W-1:0]        coefficient;
  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface
`default_nettype wire

FILE: sv/clipped_state_variable_filter_top.sv
// Clipped state variable filter: two-pole lowpass/highpass on 8-bit samples.
// The samples channel carries a signed sample and a restart flag; restart
// clears the band and low state before that sample is filtered. The results
// channel carries the lowpass and highpass words, each truncated toward zero
// to 8 bits. The cfg channel writes the unsigned Q1.14 frequency coefficient; it is
// always ready and should only be written while no sample is in flight.
// Each sample is worked in steps from acceptance to the result register: the two
// dependent products (high times coefficient, then new band times
// coefficient) go one after the other through a single shared multiplier,
// each with its own add-and-clip step. A new sample is accepted only once
// the last result is loaded, and the next one is taken while a finished word
// still waits in the output register. If the receiver stalls long enough
// that the output register is still full when the next result is ready, the
// sequencer waits and holds off further samples. Reset clears the state,
// empties the output register and restores the coefficient to about 0.1.
`default_nettype none
module clipped_state_variable_filter_top #(
  parameter int FRAC_BITS = svf_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  svf_in_if.sink    samples,
  svf_out_if.source results,
  svf_cfg_if.sink   cfg
);

  localparam int W  = svf_pkg::SAMPLE_W + FRAC_BITS;
  localparam int EW = W + 2;
  localparam int PW = W + svf_pkg::COEF_W + 1;
  localparam logic signed [EW-1:0] Q_HI = {2'b00, 8'b0111_1111, {FRAC_BITS{1'b0}}};
  localparam logic signed [EW-1:0] Q_LO = {2'b11, 8'b1000_0000, {FRAC_BITS{1'b0}}};

  svf_pkg::svf_ctrl_t ctrl;

  logic [svf_pkg::COEF_W-1:0]        coef;
  logic signed [svf_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [W-1:0]               band;
  logic signed [W-1:0]               low;
  logic signed [W-1:0]               high_q;
  logic signed [PW-1:0]              prod;
  logic signed [W-1:0]               mul_a;
  logic                              out_valid;
  logic signed [svf_pkg::SAMPLE_W-1:0] low_out_q;
  logic signed [svf_pkg::SAMPLE_W-1:0] high_out_q;

  logic signed [EW-1:0] high_raw;
  logic signed [EW-1:0] band_sum;
  logic signed [EW-1:0] low_sum;
  logic signed [W-1:0]  high_clip;
  logic signed [W-1:0]  band_clip;
  logic signed [W-1:0]  low_clip;
  logic signed [W-1:0]  low_adj;
  logic signed [W-1:0]  high_adj;
  logic signed [EW-1:0] prod_scaled;

  // clip an extended value to [-128, 127] in state format
  function automatic logic signed [W-1:0] clip_q(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    if (v > Q_HI) begin
      r = Q_HI;
    end else if (v < Q_LO) begin
      r = Q_LO;
    end else begin
      r = v;
    end
    return r[W-1:0];
  endfunction

  // truncate toward zero: bias negatives by 2^FRAC_BITS - 1
  function automatic logic signed [W-1:0] bias_neg(input logic signed [W-1:0] v);
    logic [W-1:0] bias;
    bias = v[W-1] ? {{svf_pkg::SAMPLE_W{1'b0}}, {FRAC_BITS{1'b1}}} : '0;
    return v + $signed(bias);
  endfunction

  // coefficient register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= svf_pkg::COEF_RESET;
    end else if (cfg.valid) begin
      coef <= cfg.coefficient;
    end
  end

  // sequencer
  svf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .out_busy (out_valid && !results.ready),
    .ctrl     (ctrl)
  );

  // shared multiplier, operand is high first and then the new band
  assign mul_a = ctrl.mul_sel_band ? band : high_q;

  svf_mul #(.W(W)) u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .coef (coef),
    .prod (prod)
  );

  // product shifted right by the coefficient fraction, floor rounding
  assign prod_scaled = prod[PW-1:svf_pkg::COEF_FRAC];

  // high, band and low arithmetic
  assign high_raw = $signed({{2{sample_q[svf_pkg::SAMPLE_W-1]}}, sample_q,
                             {FRAC_BITS{1'b0}}})
                  - $signed({{2{band[W-1]}}, band})
                  - $signed({{2{low[W-1]}}, low});
  assign band_sum = $signed({{2{band[W-1]}}, band}) + prod_scaled;
  assign low_sum  = $signed({{2{low[W-1]}}, low}) + prod_scaled;
  assign high_clip = clip_q(high_raw);
  assign band_clip = clip_q(band_sum);
  assign low_clip  = clip_q(low_sum);

  // sample capture and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      band <= '0;
      low  <= '0;
    end else begin
      if (ctrl.load_in && samples.restart) begin
        band <= '0;
        low  <= '0;
      end
      if (ctrl.do_band) begin
        band <= band_clip;
      end
      if (ctrl.do_low) begin
        low <= low_clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      sample_q <= samples.sample;
    end
    if (ctrl.do_high) begin
      high_q <= high_clip;
    end
  end

  // output word, both values truncated toward zero
  assign low_adj  = bias_neg(low);
  assign high_adj = bias_neg(high_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      low_out_q  <= low_adj[W-1:FRAC_BITS];
      high_out_q <= high_adj[W-1:FRAC_BITS];
    end
  end

  assign results.valid    = out_valid;
  assign results.low_out  = low_out_q;
  assign results.high_out = high_out_q;

endmodule
`default_nettype wire

FILE: sv/svf_mul.sv
// shared signed-by-coefficient multiplier with registered product
`default_nettype none
module svf_mul #(
  parameter int W = svf_pkg::SAMPLE_W + svf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [W-1:0]               a,
  input  wire logic [svf_pkg::COEF_W-1:0]        coef,
  output      logic signed [W+svf_pkg::COEF_W:0] prod
);

  logic signed [svf_pkg::COEF_W:0] coef_s;

  // coefficient is unsigned, give it a zero sign bit
  assign coef_s = $signed({1'b0, coef});

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * coef_s;
    end
  end

endmodule
`default_nettype wire

FILE: sv/svf_ctrl.sv
// sequencer for one filter step: high, band product, band, low product, low, word out
`default_nettype none
module svf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               out_busy,
  output      svf_pkg::svf_ctrl_t ctrl
);

  svf_pkg::svf_state_t state;
  svf_pkg::svf_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctrl       = '0;
    case (state)
      svf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_next   = svf_pkg::ST_HIGH;
        end
      end
      svf_pkg::ST_HIGH: begin
        ctrl.do_high = 1'b1;
        state_next   = svf_pkg::ST_MUL_HIGH;
      end
      svf_pkg::ST_MUL_HIGH: begin
        ctrl.mul_en = 1'b1;
        state_next  = svf_pkg::ST_BAND;
      end
      svf_pkg::ST_BAND: begin
        ctrl.do_band = 1'b1;
        state_next   = svf_pkg::ST_MUL_BAND;
      end
      svf_pkg::ST_MUL_BAND: begin
        ctrl.mul_en       = 1'b1;
        ctrl.mul_sel_band = 1'b1;
        state_next        = svf_pkg::ST_LOW;
      end
      svf_pkg::ST_LOW: begin
        ctrl.do_low = 1'b1;
        state_next  = svf_pkg::ST_OUT;
      end
      svf_pkg::ST_OUT: begin
        // hold until the output register is free
        if (!out_busy) begin
          ctrl.load_out = 1'b1;
          state_next    = svf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = svf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// self-checking bench for the clipped state variable filter: directed and random samples
`default_nettype none
module testbench;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_ITEMS    = 140;

  localparam int SAMPLE_W = svf_pkg::SAMPLE_W;
  localparam int COEF_W   = svf_pkg::COEF_W;
  localparam int FRAC     = svf_pkg::FRAC_BITS_DEF;
  localparam int STATE_W  = SAMPLE_W + FRAC;
  localparam logic signed [39:0] STATE_TOP    = 40'sd127 <<< FRAC;
  localparam logic signed [39:0] STATE_BOTTOM = -(40'sd128 <<< FRAC);

  typedef logic signed [STATE_W-1:0] state_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
  } sample_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] low_out;
    logic signed [SAMPLE_W-1:0] high_out;
  } filter_word_t;

  // waveform shapes used for random segments
  typedef enum int {WAVE_NOISE, WAVE_SQUARE, WAVE_RAIL, WAVE_RAMP} wave_kind_t;

  logic clk = 1'b0;
  logic rst;

  svf_in_if  samples_if ();
  svf_out_if results_if ();
  svf_cfg_if cfg_if ();

  clipped_state_variable_filter_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // filter state mirrored by the bench
  logic [COEF_W-1:0] filter_coef = svf_pkg::COEF_RESET;
  state_word_t       band_q = '0;
  state_word_t       low_q = '0;

  sample_word_t sample_backlog[$];
  filter_word_t predicted_words[$];

  bit idle_bursts = 1'b1;
  bit hold_phase  = 1'b0;
  logic long_hold = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int mismatch_count = 0;

  // clip a wide value to the state range
  function automatic state_word_t clip_state(input logic signed [39:0] v);
    if (v > STATE_TOP) return STATE_TOP[STATE_W-1:0];
    if (v < STATE_BOTTOM) return STATE_BOTTOM[STATE_W-1:0];
    return v[STATE_W-1:0];
  endfunction

  // value times coefficient, floor-shifted back to state scale
  function automatic logic signed [39:0] coef_scale(input state_word_t v);
    logic signed [39:0] prod;
    prod = $signed(v) * $signed({1'b0, filter_coef});
    return prod >>> svf_pkg::COEF_FRAC;
  endfunction

  // integer part, rounded toward zero
  function automatic logic signed [SAMPLE_W-1:0] whole_part(input state_word_t v);
    logic signed [39:0] t;
    t = v;
    if (t < 0) t = -((-t) >>> FRAC);
    else t = t >>> FRAC;
    return t[SAMPLE_W-1:0];
  endfunction

  // one filter step on the mirrored state
  function automatic filter_word_t svf_step(input sample_word_t w);
    logic signed [39:0] high_full;
    logic signed [39:0] sample_q;
    state_word_t        high_c;
    filter_word_t       r;
    if (w.restart) begin
      band_q = '0;
      low_q  = '0;
    end
    sample_q  = $signed(w.sample);
    high_full = (sample_q <<< FRAC) - band_q - low_q;
    high_c    = clip_state(high_full);
    band_q    = clip_state(band_q + coef_scale(high_c));
    low_q     = clip_state(low_q + coef_scale(band_q));
    r.low_out  = whole_part(low_q);
    r.high_out = whole_part(high_c);
    return r;
  endfunction

  // sample driver: holds each word until taken, idles in short bursts
  always @(posedge clk) begin
    sample_word_t w;
    if (rst) begin
      samples_if.valid   <= 1'b0;
      samples_if.sample  <= '0;
      samples_if.restart <= 1'b0;
      send_gap = 0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        w.sample  = samples_if.sample;
        w.restart = samples_if.restart;
        predicted_words.push_back(svf_step(w));
      end
      if (!samples_if.valid || samples_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          samples_if.valid <= 1'b0;
        end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 4);
          samples_if.valid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          w = sample_backlog.pop_front();
          samples_if.valid   <= 1'b1;
          samples_if.sample  <= w.sample;
          samples_if.restart <= w.restart;
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each word, stalls in short bursts and during the long hold
  always @(posedge clk) begin
    filter_word_t want;
    if (rst) begin
      results_if.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (predicted_words.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("unexpected word: low %0d high %0d",
                     results_if.low_out, results_if.high_out);
          mismatch_count++;
        end else begin
          want = predicted_words.pop_front();
          if (results_if.low_out !== want.low_out ||
              results_if.high_out !== want.high_out) begin
            if (mismatch_count < REPORT_LIMIT)
              $display("mismatch at %0t: low exp %0d got %0d, high exp %0d got %0d",
                       $time, want.low_out, results_if.low_out,
                       want.high_out, results_if.high_out);
            mismatch_count++;
          end
        end
      end
      if (long_hold) begin
        results_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        results_if.ready <= 1'b0;
      end else if (idle_bursts && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 4);
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (hold_phase);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Regression FAIL");
    $finish;
  end

  task automatic add_word(input int s, input bit r);
    sample_word_t w;
    w.sample  = s[SAMPLE_W-1:0];
    w.restart = r;
    sample_backlog.push_back(w);
  endtask

  // well-formed segments: restart then a shaped waveform; some broken ones
  task automatic add_segments(input int n_items);
    int         count;
    int         len;
    int         amp;
    int         period;
    int         step;
    int         s;
    bit         broken;
    bit         r;
    wave_kind_t kind;
    count = 0;
    while (count < n_items) begin
      kind   = wave_kind_t'($urandom_range(0, 3));
      len    = $urandom_range(4, 60);
      amp    = $urandom_range(1, 128);
      period = $urandom_range(1, 20);
      step   = $urandom_range(1, 40);
      broken = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len && count < n_items; i++) begin
        case (kind)
          WAVE_NOISE:  s = $urandom_range(0, 255);
          WAVE_SQUARE: s = ((i / period) % 2) ? amp - 1 : -amp;
          WAVE_RAIL:   s = $urandom_range(0, 1) ? 127 : -128;
          default:     s = i * step;
        endcase
        r = broken ? ($urandom_range(0, 7) == 0) : (i == 0);
        add_word(s, r);
        count++;
      end
    end
  endtask

  // wait until every word is taken and every result is back
  task automatic wait_drained();
    while (sample_backlog.size() != 0 || samples_if.valid || predicted_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coefficient(input logic [COEF_W-1:0] v);
    @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.coefficient <= v;
    do @(posedge clk); while (!cfg_if.ready);
    filter_coef = v;
    cfg_if.valid <= 1'b0;
  endtask

  // random coefficient: file-style steps, tiny values or full range
  function automatic logic [COEF_W-1:0] pick_coefficient();
    int k;
    k = $urandom_range(0, 50);
    case ($urandom_range(0, 2))
      0:       return COEF_W'(((8 + 3 * k) * 16384) / 80);
      1:       return COEF_W'($urandom_range(0, 200));
      default: return COEF_W'($urandom_range(0, 32767));
    endcase
  endfunction

  // stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_if.valid       = 1'b0;
    cfg_if.coefficient = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed, reset coefficient: rails, small values, restart mid-stream
    add_word(0, 1'b1);
    repeat (3) add_word(127, 1'b0);
    repeat (3) add_word(-128, 1'b0);
    add_word(-1, 1'b1);
    add_word(1, 1'b0);
    add_word(-128, 1'b1);
    add_word(127, 1'b1);
    wait_drained();

    // directed, largest coefficient: drive both state clip bounds
    write_coefficient(COEF_W'(32767));
    add_word(127, 1'b1);
    repeat (3) add_word(127, 1'b0);
    repeat (4) add_word(-128, 1'b0);
    add_word(0, 1'b1);
    add_word(-1, 1'b0);
    add_word(85, 1'b0);
    add_word(-86, 1'b0);
    wait_drained();

    add_segments(PHASE_ITEMS);
    wait_drained();

    write_coefficient('0);
    add_segments(PHASE_ITEMS);
    wait_drained();

    // receiver held off while samples keep coming
    write_coefficient(COEF_W'(16384));
    hold_phase = 1'b1;
    add_segments(80);
    wait_drained();

    for (int p = 0; p < 7; p++) begin
      write_coefficient(pick_coefficient());
      idle_bursts = (p != 3);
      add_segments(PHASE_ITEMS);
      wait_drained();
    end

    // closing stretch at full rate
    write_coefficient(svf_pkg::COEF_RESET);
    idle_bursts = 1'b0;
    add_segments(200);
    wait_drained();

    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
sv/svf_pkg.sv
sv/svf_if.sv
sv/svf_mul.sv
sv/svf_ctrl.sv
sv/clipped_state_variable_filter_top.sv
tb/testbench.sv
